// File: src/gas_pkg.sv
// ---------------------------------------------------------------------------
// gas_pkg
// Shared types, constants and helpers of the grid path search block.
// ---------------------------------------------------------------------------
`default_nettype none
package gas_pkg;

  localparam int SIDE     = 32;
  localparam int SIDE_W   = 5;
  localparam int CELLS    = SIDE * SIDE;
  localparam int CELL_W   = 2 * SIDE_W;
  localparam int G_W      = 19;
  localparam int F_W      = 20;
  localparam int KEY_W    = F_W + CELL_W;
  localparam int LEN_W    = CELL_W + 1;
  localparam int DIM_W    = 6;
  localparam int COORD_W  = 6;
  localparam logic [G_W-1:0] G_LIMIT = '1;
  localparam logic [G_W-1:0] STRAIGHT_COST = 19'd256;
  localparam logic [G_W-1:0] DIAGONAL_COST = 19'd362;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_FIND  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_PATH   = 3'd1,
    ST_SAME      = 3'd2,
    ST_DEST_WALL = 3'd3,
    ST_RANGE     = 3'd4,
    ST_BAD_READ  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    FL_FREE   = 2'd0,
    FL_OPEN   = 2'd1,
    FL_CLOSED = 2'd2
  } flag_t;

  typedef enum logic [4:0] {
    S_CLRW, S_IDLE, S_F_DW, S_CLRF, S_INIT, S_POP, S_POP_B, S_POP_C,
    S_SD_L, S_SD_R, S_SD_D, S_NB_A, S_NB_B, S_NB_C, S_NB_D, S_NB_E,
    S_NB_NEXT, S_SU, S_SU_D, S_PATH, S_PATH_R, S_RD, S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [LEN_W-1:0]   path_length;
    logic [COORD_W-1:0] path_x;
    logic [COORD_W-1:0] path_z;
    logic [G_W-1:0]     path_cost;
  } result_t;

  // column step of a direction, 7-bit two's complement
  function automatic logic [6:0] dir_dc(input logic [2:0] d);
    logic [6:0] v;
    unique case (d)
      3'd0, 3'd4, 3'd5: v = 7'h7f;
      3'd1, 3'd6, 3'd7: v = 7'h01;
      default:          v = 7'h00;
    endcase
    return v;
  endfunction

  function automatic logic [6:0] dir_dr(input logic [2:0] d);
    logic [6:0] v;
    unique case (d)
      3'd2, 3'd4, 3'd6: v = 7'h7f;
      3'd3, 3'd5, 3'd7: v = 7'h01;
      default:          v = 7'h00;
    endcase
    return v;
  endfunction

  // row-major index as the grid in use sees it
  function automatic logic [CELL_W-1:0] lin(input logic [SIDE_W-1:0] r,
                                            input logic [SIDE_W-1:0] c,
                                            input logic [DIM_W-1:0] w);
    logic [LEN_W-1:0] t;
    t = LEN_W'(r) * LEN_W'(w) + LEN_W'(c);
    return t[CELL_W-1:0];
  endfunction

  function automatic logic [F_W-1:0] heur(input logic [SIDE_W-1:0] r,
                                          input logic [SIDE_W-1:0] c,
                                          input logic [SIDE_W-1:0] dr,
                                          input logic [SIDE_W-1:0] dc);
    logic [SIDE_W-1:0] ar, ac;
    logic [SIDE_W:0]   s;
    ar = (r > dr) ? r - dr : dr - r;
    ac = (c > dc) ? c - dc : dc - c;
    s  = {1'b0, ar} + {1'b0, ac};
    return {{(F_W-SIDE_W-9){1'b0}}, s, 8'h00};
  endfunction

endpackage
`default_nettype wire

// File: src/gas_ram.sv
// ---------------------------------------------------------------------------
// gas_ram
// Simple dual-port memory, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module gas_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: src/gas_core.sv
// ---------------------------------------------------------------------------
// gas_core
// Search sequencer: cell memories, binary heap open list, path store and
// the result word register.
// ---------------------------------------------------------------------------
`default_nettype none
module gas_core #(
  parameter int CELLS  = gas_pkg::CELLS,
  parameter int CELL_W = gas_pkg::CELL_W
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [gas_pkg::DIM_W-1:0]    grid_w,
  input  wire logic [gas_pkg::DIM_W-1:0]    grid_h,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   in_action,
  input  wire logic [CELL_W-1:0]            in_cell_index,
  input  wire logic                         in_is_wall,
  input  wire logic [5:0]                   in_start_x,
  input  wire logic [5:0]                   in_start_z,
  input  wire logic [5:0]                   in_dest_x,
  input  wire logic [5:0]                   in_dest_z,
  input  wire logic [CELL_W-1:0]            in_path_pos,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output gas_pkg::result_t                  out_res
);

  localparam int SW = gas_pkg::SIDE_W;
  localparam int KW = gas_pkg::KEY_W;
  localparam int GW = gas_pkg::G_W;
  localparam int FW = gas_pkg::F_W;
  localparam int LW = gas_pkg::LEN_W;
  localparam int DW = gas_pkg::DIM_W;

  gas_pkg::state_t  state_r, state_nxt;
  gas_pkg::result_t res_r, res_nxt, out_res_r;
  logic             out_valid_r;

  logic [DW-1:0]     w_r, w_nxt, h_r, h_nxt;
  logic [SW-1:0]     sr_r, sr_nxt, sc_r, sc_nxt, er_r, er_nxt, ec_r, ec_nxt;
  logic [LW-1:0]     ncells_r, ncells_nxt;
  logic [SW-1:0]     hw_r, hw_nxt, hh_r, hh_nxt;
  logic [LW-1:0]     slen_r, slen_nxt;
  logic [GW-1:0]     scost_r, scost_nxt;
  logic [CELL_W-1:0] cnt_r, cnt_nxt;
  logic [LW-1:0]     count_r, count_nxt;
  logic [CELL_W-1:0] cur_r, cur_nxt;
  logic [GW-1:0]     gcur_r, gcur_nxt;
  logic [KW-1:0]     key_r, key_nxt, lkey_r, lkey_nxt;
  logic [CELL_W-1:0] s_r, s_nxt;
  logic              has_r_r, has_r_nxt;
  logic [2:0]        dir_r, dir_nxt;
  logic [SW-1:0]     nr_r, nr_nxt, nc_r, nc_nxt;
  logic [1:0]        fadj_r, fadj_nxt;
  logic [GW-1:0]     gadj_r, gadj_nxt;
  logic [CELL_W-1:0] sadj_r, sadj_nxt;
  logic [CELL_W-1:0] pc_r, pc_nxt;
  logic [LW-1:0]     pn_r, pn_nxt;

  logic              wall_we, flag_we, g_we, par_we, slot_we, heap_we, path_we;
  logic [CELL_W-1:0] wall_wa, wall_ra, flag_wa, flag_ra, g_wa, g_ra, par_wa, par_ra;
  logic [CELL_W-1:0] slot_wa, slot_ra, heap_wa, heap_ra, path_wa, path_ra;
  logic              wall_wd, wall_rd;
  logic [1:0]        flag_wd, flag_rd;
  logic [GW-1:0]     g_wd, g_rd;
  logic [CELL_W-1:0] par_wd, par_rd, slot_wd, slot_rd, path_wd, path_rd;
  logic [KW-1:0]     heap_wd, heap_rd;

  gas_ram #(.WIDTH(1), .DEPTH(CELLS)) u_wall (.clk, .we(wall_we), .waddr(wall_wa),
    .wdata(wall_wd), .raddr(wall_ra), .rdata(wall_rd));
  gas_ram #(.WIDTH(2), .DEPTH(CELLS)) u_flag (.clk, .we(flag_we), .waddr(flag_wa),
    .wdata(flag_wd), .raddr(flag_ra), .rdata(flag_rd));
  gas_ram #(.WIDTH(GW), .DEPTH(CELLS)) u_g (.clk, .we(g_we), .waddr(g_wa),
    .wdata(g_wd), .raddr(g_ra), .rdata(g_rd));
  gas_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_par (.clk, .we(par_we), .waddr(par_wa),
    .wdata(par_wd), .raddr(par_ra), .rdata(par_rd));
  gas_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_slot (.clk, .we(slot_we), .waddr(slot_wa),
    .wdata(slot_wd), .raddr(slot_ra), .rdata(slot_rd));
  gas_ram #(.WIDTH(KW), .DEPTH(CELLS)) u_heap (.clk, .we(heap_we), .waddr(heap_wa),
    .wdata(heap_wd), .raddr(heap_ra), .rdata(heap_rd));
  gas_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_path (.clk, .we(path_we), .waddr(path_wa),
    .wdata(path_wd), .raddr(path_ra), .rdata(path_rd));

  // find decode
  logic [7:0] sx_e, sz_e, dx_e, dz_e, half_w, half_h, f_sc, f_sr, f_ec, f_er;
  logic       f_range_bad, f_same;
  assign half_w = {3'b0, grid_w[DW-1:1]};
  assign half_h = {3'b0, grid_h[DW-1:1]};
  assign sx_e = {{2{in_start_x[5]}}, in_start_x};
  assign sz_e = {{2{in_start_z[5]}}, in_start_z};
  assign dx_e = {{2{in_dest_x[5]}}, in_dest_x};
  assign dz_e = {{2{in_dest_z[5]}}, in_dest_z};
  assign f_sc = sx_e + half_w;
  assign f_sr = half_h - sz_e;
  assign f_ec = dx_e + half_w;
  assign f_er = half_h - dz_e;
  assign f_range_bad = f_sc[7] | f_sr[7] | f_ec[7] | f_er[7] |
                       (f_sc >= {2'b0, grid_w}) | (f_ec >= {2'b0, grid_w}) |
                       (f_sr >= {2'b0, grid_h}) | (f_er >= {2'b0, grid_h});
  assign f_same = (f_sc == f_ec) && (f_sr == f_er);

  logic accept, out_free;
  assign accept   = in_valid && (state_r == gas_pkg::S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // neighbor step
  logic [SW-1:0] cr, cc;
  logic [6:0]    nb_c, nb_r;
  logic          nb_out, diag;
  assign cr   = cur_r[CELL_W-1:SW];
  assign cc   = cur_r[SW-1:0];
  assign nb_c = {2'b0, cc} + gas_pkg::dir_dc(dir_r);
  assign nb_r = {2'b0, cr} + gas_pkg::dir_dr(dir_r);
  assign nb_out = nb_c[6] | nb_r[6] | (nb_c >= {1'b0, w_r}) | (nb_r >= {1'b0, h_r});
  assign diag = dir_r[2];

  logic [FW-1:0]     g_sum;
  logic [GW-1:0]     g_new;
  logic [FW-1:0]     f_new;
  logic [CELL_W-1:0] adj;
  assign adj   = {nr_r, nc_r};
  assign g_sum = {1'b0, gcur_r} +
                 {1'b0, (diag ? gas_pkg::DIAGONAL_COST : gas_pkg::STRAIGHT_COST)};
  assign g_new = (g_sum > {1'b0, gas_pkg::G_LIMIT}) ? gas_pkg::G_LIMIT : g_sum[GW-1:0];
  assign f_new = {1'b0, g_new} + gas_pkg::heur(nr_r, nc_r, er_r, ec_r);

  // heap helpers
  logic [LW-1:0]     sd_l, sd_rr;
  logic [KW-1:0]     sd_cand;
  logic [CELL_W-1:0] sd_cand_s, su_up;
  logic              sd_swap, su_swap, pop_hit, path_end;
  assign sd_l      = {s_r, 1'b1};
  assign sd_rr     = sd_l + LW'(1);
  assign sd_cand   = (has_r_r && heap_rd < lkey_r) ? heap_rd : lkey_r;
  assign sd_cand_s = (has_r_r && heap_rd < lkey_r) ? sd_rr[CELL_W-1:0] : sd_l[CELL_W-1:0];
  assign sd_swap   = sd_cand < key_r;
  assign su_up     = (s_r - CELL_W'(1)) >> 1;
  assign su_swap   = key_r < heap_rd;
  assign pop_hit   = cur_r == {er_r, ec_r};
  assign path_end  = (pc_r == {sr_r, sc_r}) || ((pn_r + LW'(1)) >= ncells_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gas_pkg::S_CLRW:
        if (cnt_r == CELL_W'(CELLS - 1)) state_nxt = gas_pkg::S_IDLE;
      gas_pkg::S_IDLE:
        if (accept) begin
          if (in_action == gas_pkg::ACT_FIND && !f_range_bad && !f_same) begin
            state_nxt = gas_pkg::S_F_DW;
          end else if (in_action == gas_pkg::ACT_READ && LW'(in_path_pos) < slen_r) begin
            state_nxt = gas_pkg::S_RD;
          end else begin
            state_nxt = gas_pkg::S_DONE;
          end
        end
      gas_pkg::S_F_DW:  state_nxt = wall_rd ? gas_pkg::S_DONE : gas_pkg::S_CLRF;
      gas_pkg::S_CLRF:
        if (cnt_r == CELL_W'(CELLS - 1)) state_nxt = gas_pkg::S_INIT;
      gas_pkg::S_INIT:  state_nxt = gas_pkg::S_POP;
      gas_pkg::S_POP:   state_nxt = (count_r == '0) ? gas_pkg::S_DONE : gas_pkg::S_POP_B;
      gas_pkg::S_POP_B: state_nxt = gas_pkg::S_POP_C;
      gas_pkg::S_POP_C: begin
        if (pop_hit) state_nxt = gas_pkg::S_PATH;
        else if (count_r != LW'(1)) state_nxt = gas_pkg::S_SD_L;
        else state_nxt = gas_pkg::S_NB_A;
      end
      gas_pkg::S_SD_L:  state_nxt = (sd_l < count_r) ? gas_pkg::S_SD_R : gas_pkg::S_NB_A;
      gas_pkg::S_SD_R:  state_nxt = gas_pkg::S_SD_D;
      gas_pkg::S_SD_D:  state_nxt = sd_swap ? gas_pkg::S_SD_L : gas_pkg::S_NB_A;
      gas_pkg::S_NB_A:  state_nxt = nb_out ? gas_pkg::S_NB_NEXT : gas_pkg::S_NB_B;
      gas_pkg::S_NB_B: begin
        if (wall_rd || flag_rd == gas_pkg::FL_CLOSED) state_nxt = gas_pkg::S_NB_NEXT;
        else if (diag) state_nxt = gas_pkg::S_NB_C;
        else state_nxt = gas_pkg::S_NB_E;
      end
      gas_pkg::S_NB_C:  state_nxt = wall_rd ? gas_pkg::S_NB_NEXT : gas_pkg::S_NB_D;
      gas_pkg::S_NB_D:  state_nxt = wall_rd ? gas_pkg::S_NB_NEXT : gas_pkg::S_NB_E;
      gas_pkg::S_NB_E: begin
        if (fadj_r == gas_pkg::FL_OPEN && !(g_new < gadj_r)) state_nxt = gas_pkg::S_NB_NEXT;
        else state_nxt = gas_pkg::S_SU;
      end
      gas_pkg::S_NB_NEXT: state_nxt = (dir_r == 3'd7) ? gas_pkg::S_POP : gas_pkg::S_NB_A;
      gas_pkg::S_SU:    state_nxt = (s_r == '0) ? gas_pkg::S_NB_NEXT : gas_pkg::S_SU_D;
      gas_pkg::S_SU_D:  state_nxt = su_swap ? gas_pkg::S_SU : gas_pkg::S_NB_NEXT;
      gas_pkg::S_PATH:  state_nxt = path_end ? gas_pkg::S_DONE : gas_pkg::S_PATH_R;
      gas_pkg::S_PATH_R: state_nxt = gas_pkg::S_PATH;
      gas_pkg::S_RD:    state_nxt = gas_pkg::S_DONE;
      gas_pkg::S_DONE:  if (out_free) state_nxt = gas_pkg::S_IDLE;
      default:          state_nxt = gas_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    res_nxt = res_r;
    w_nxt = w_r;  h_nxt = h_r;
    sr_nxt = sr_r; sc_nxt = sc_r; er_nxt = er_r; ec_nxt = ec_r;
    ncells_nxt = ncells_r; hw_nxt = hw_r; hh_nxt = hh_r;
    slen_nxt = slen_r; scost_nxt = scost_r;
    cnt_nxt = cnt_r; count_nxt = count_r; cur_nxt = cur_r; gcur_nxt = gcur_r;
    key_nxt = key_r; lkey_nxt = lkey_r; s_nxt = s_r; has_r_nxt = has_r_r;
    dir_nxt = dir_r; nr_nxt = nr_r; nc_nxt = nc_r;
    fadj_nxt = fadj_r; gadj_nxt = gadj_r; sadj_nxt = sadj_r;
    pc_nxt = pc_r; pn_nxt = pn_r;
    wall_we = 1'b0; wall_wa = cnt_r; wall_wd = 1'b0; wall_ra = '0;
    flag_we = 1'b0; flag_wa = cnt_r; flag_wd = gas_pkg::FL_FREE; flag_ra = adj;
    g_we = 1'b0; g_wa = adj; g_wd = g_new; g_ra = adj;
    par_we = 1'b0; par_wa = adj; par_wd = cur_r; par_ra = pc_r;
    slot_we = 1'b0; slot_wa = key_r[CELL_W-1:0]; slot_wd = s_r; slot_ra = adj;
    heap_we = 1'b0; heap_wa = s_r; heap_wd = key_r; heap_ra = '0;
    path_we = 1'b0; path_wa = pn_r[CELL_W-1:0]; path_wd = pc_r;
    path_ra = in_path_pos;
    unique case (state_r)
      gas_pkg::S_CLRW: begin
        wall_we = 1'b1;
        cnt_nxt = cnt_r + CELL_W'(1);
      end
      gas_pkg::S_IDLE:
        if (accept) begin
          res_nxt = '0;
          res_nxt.path_length = slen_r;
          unique case (in_action)
            gas_pkg::ACT_WRITE: begin
              wall_we = 1'b1;
              wall_wa = in_cell_index;
              wall_wd = in_is_wall;
            end
            gas_pkg::ACT_FIND: begin
              slen_nxt = '0;
              scost_nxt = '0;
              res_nxt.path_length = '0;
              w_nxt = grid_w;
              h_nxt = grid_h;
              sr_nxt = f_sr[SW-1:0]; sc_nxt = f_sc[SW-1:0];
              er_nxt = f_er[SW-1:0]; ec_nxt = f_ec[SW-1:0];
              ncells_nxt = LW'(grid_w) * LW'(grid_h);
              wall_ra = gas_pkg::lin(f_er[SW-1:0], f_ec[SW-1:0], grid_w);
              cnt_nxt = '0;
              if (f_range_bad) res_nxt.status = gas_pkg::ST_RANGE;
              else if (f_same) res_nxt.status = gas_pkg::ST_SAME;
            end
            gas_pkg::ACT_READ:
              if (!(LW'(in_path_pos) < slen_r)) res_nxt.status = gas_pkg::ST_BAD_READ;
            default: res_nxt.status = gas_pkg::ST_BAD_READ;
          endcase
        end
      gas_pkg::S_F_DW:
        if (wall_rd) res_nxt.status = gas_pkg::ST_DEST_WALL;
      gas_pkg::S_CLRF: begin
        flag_we = 1'b1;
        cnt_nxt = cnt_r + CELL_W'(1);
      end
      gas_pkg::S_INIT: begin
        g_we = 1'b1; g_wa = {sr_r, sc_r}; g_wd = '0;
        par_we = 1'b1; par_wa = {sr_r, sc_r}; par_wd = {sr_r, sc_r};
        flag_we = 1'b1; flag_wa = {sr_r, sc_r}; flag_wd = gas_pkg::FL_OPEN;
        heap_we = 1'b1; heap_wa = '0;
        heap_wd = {gas_pkg::heur(sr_r, sc_r, er_r, ec_r), sr_r, sc_r};
        slot_we = 1'b1; slot_wa = {sr_r, sc_r}; slot_wd = '0;
        count_nxt = LW'(1);
      end
      gas_pkg::S_POP:
        if (count_r == '0) res_nxt.status = gas_pkg::ST_NO_PATH;
      gas_pkg::S_POP_B: begin
        cur_nxt = heap_rd[CELL_W-1:0];
        heap_ra = CELL_W'(count_r - LW'(1));
        g_ra = heap_rd[CELL_W-1:0];
        flag_we = 1'b1; flag_wa = heap_rd[CELL_W-1:0]; flag_wd = gas_pkg::FL_CLOSED;
      end
      gas_pkg::S_POP_C: begin
        gcur_nxt = g_rd;
        dir_nxt = '0;
        if (pop_hit) begin
          pc_nxt = cur_r;
          pn_nxt = '0;
        end else begin
          count_nxt = count_r - LW'(1);
          key_nxt = heap_rd;
          s_nxt = '0;
        end
      end
      gas_pkg::S_SD_L:
        if (sd_l < count_r) begin
          heap_ra = sd_l[CELL_W-1:0];
        end else begin
          heap_we = 1'b1;
          slot_we = 1'b1;
        end
      gas_pkg::S_SD_R: begin
        lkey_nxt = heap_rd;
        has_r_nxt = sd_rr < count_r;
        heap_ra = sd_rr[CELL_W-1:0];
      end
      gas_pkg::S_SD_D: begin
        heap_we = 1'b1;
        slot_we = 1'b1;
        if (sd_swap) begin
          heap_wd = sd_cand;
          slot_wa = sd_cand[CELL_W-1:0];
          s_nxt = sd_cand_s;
        end
      end
      gas_pkg::S_NB_A: begin
        nr_nxt = nb_r[SW-1:0];
        nc_nxt = nb_c[SW-1:0];
        wall_ra = gas_pkg::lin(nb_r[SW-1:0], nb_c[SW-1:0], w_r);
        flag_ra = {nb_r[SW-1:0], nb_c[SW-1:0]};
        g_ra = {nb_r[SW-1:0], nb_c[SW-1:0]};
        slot_ra = {nb_r[SW-1:0], nb_c[SW-1:0]};
      end
      gas_pkg::S_NB_B: begin
        fadj_nxt = flag_rd;
        gadj_nxt = g_rd;
        sadj_nxt = slot_rd;
        wall_ra = gas_pkg::lin(cr, nc_r, w_r);
      end
      gas_pkg::S_NB_C: wall_ra = gas_pkg::lin(nr_r, cc, w_r);
      gas_pkg::S_NB_D: ;
      gas_pkg::S_NB_E:
        if (fadj_r == gas_pkg::FL_OPEN) begin
          if (g_new < gadj_r) begin
            par_we = 1'b1;
            g_we = 1'b1;
            key_nxt = {f_new, adj};
            s_nxt = sadj_r;
          end
        end else begin
          par_we = 1'b1;
          g_we = 1'b1;
          flag_we = 1'b1; flag_wa = adj; flag_wd = gas_pkg::FL_OPEN;
          key_nxt = {f_new, adj};
          s_nxt = count_r[CELL_W-1:0];
          count_nxt = count_r + LW'(1);
        end
      gas_pkg::S_NB_NEXT: dir_nxt = dir_r + 3'd1;
      gas_pkg::S_SU:
        if (s_r == '0) begin
          heap_we = 1'b1;
          slot_we = 1'b1;
        end else begin
          heap_ra = su_up;
        end
      gas_pkg::S_SU_D: begin
        heap_we = 1'b1;
        slot_we = 1'b1;
        if (su_swap) begin
          heap_wd = heap_rd;
          slot_wa = heap_rd[CELL_W-1:0];
          s_nxt = su_up;
        end
      end
      gas_pkg::S_PATH: begin
        path_we = 1'b1;
        pn_nxt = pn_r + LW'(1);
        if (path_end) begin
          slen_nxt = pn_r + LW'(1);
          scost_nxt = gcur_r;
          hw_nxt = w_r[DW-1:1];
          hh_nxt = h_r[DW-1:1];
          res_nxt.status = gas_pkg::ST_OK;
          res_nxt.path_length = pn_r + LW'(1);
          res_nxt.path_cost = gcur_r;
        end
      end
      gas_pkg::S_PATH_R: pc_nxt = par_rd;
      gas_pkg::S_RD: begin
        res_nxt.path_x = 6'({1'b0, path_rd[SW-1:0]} - {1'b0, hw_r});
        res_nxt.path_z = 6'({1'b0, hh_r} - {1'b0, path_rd[CELL_W-1:SW]});
        res_nxt.path_cost = scost_r;
      end
      gas_pkg::S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gas_pkg::S_CLRW;
      cnt_r       <= '0;
      count_r     <= '0;
      slen_r      <= '0;
      scost_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      count_r <= count_nxt;
      slen_r  <= slen_nxt;
      scost_r <= scost_nxt;
      if (state_r == gas_pkg::S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (state_r == gas_pkg::S_DONE && out_free) begin
      out_res_r <= res_r;
    end
    w_r <= w_nxt; h_r <= h_nxt;
    sr_r <= sr_nxt; sc_r <= sc_nxt; er_r <= er_nxt; ec_r <= ec_nxt;
    ncells_r <= ncells_nxt; hw_r <= hw_nxt; hh_r <= hh_nxt;
    cur_r <= cur_nxt; gcur_r <= gcur_nxt;
    key_r <= key_nxt; lkey_r <= lkey_nxt; s_r <= s_nxt; has_r_r <= has_r_nxt;
    dir_r <= dir_nxt; nr_r <= nr_nxt; nc_r <= nc_nxt;
    fadj_r <= fadj_nxt; gadj_r <= gadj_nxt; sadj_r <= sadj_nxt;
    pc_r <= pc_nxt; pn_r <= pn_nxt;
  end

  assign in_stall  = state_r != gas_pkg::S_IDLE;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_heap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LW'(CELLS)) else $error("open list over capacity");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != gas_pkg::S_IDLE) else $error("accepted word not taken up");
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == gas_pkg::S_DONE))
    else $error("result word without finished item");
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slen_r <= LW'(CELLS)) else $error("stored path too long");

endmodule
`default_nettype wire

// File: src/grid_astar_path_search_top.sv
// ---------------------------------------------------------------------------
// grid_astar_path_search_top
// A* search on an 8-connected walled grid with a register port and path store.
// ---------------------------------------------------------------------------
// Find: a sweep first clears the flag memory, then each expanded cell is
// popped from the heap and sifted down level by level, and its 8 neighbors
// are visited with a sift-up level by level on insert or update; then the
// path is stored cell by cell. One item at a time.
// After reset the wall map is cleared with in_stall high.
`default_nettype none
module grid_astar_path_search_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [9:0]  in_cell_index,
  input  wire logic        in_is_wall,
  input  wire logic [5:0]  in_start_x,
  input  wire logic [5:0]  in_start_z,
  input  wire logic [5:0]  in_dest_x,
  input  wire logic [5:0]  in_dest_z,
  input  wire logic [9:0]  in_path_pos,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [10:0]      out_path_length,
  output logic [5:0]       out_path_x,
  output logic [5:0]       out_path_z,
  output logic [18:0]      out_path_cost
);

  localparam int DW = gas_pkg::DIM_W;

  logic [DW-1:0] width_r, width_nxt, height_r, height_nxt;
  logic [DW-1:0] w_use, h_use;
  logic          wr_en;
  gas_pkg::result_t res;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr_en) begin
      if (paddr[2]) height_nxt = pwdata[DW-1:0];
      else width_nxt = pwdata[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DW'(gas_pkg::SIDE);
      height_r <= DW'(gas_pkg::SIDE);
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  assign prdata = paddr[2] ? {26'b0, height_r} : {26'b0, width_r};

  assign w_use = (width_r == '0) ? DW'(1) :
                 (width_r > DW'(gas_pkg::SIDE)) ? DW'(gas_pkg::SIDE) : width_r;
  assign h_use = (height_r == '0) ? DW'(1) :
                 (height_r > DW'(gas_pkg::SIDE)) ? DW'(gas_pkg::SIDE) : height_r;

  gas_core #(
    .CELLS (gas_pkg::CELLS),
    .CELL_W(gas_pkg::CELL_W)
  ) u_core (
    .clk, .rst_n,
    .grid_w(w_use), .grid_h(h_use),
    .in_valid, .in_stall, .in_action, .in_cell_index, .in_is_wall,
    .in_start_x, .in_start_z, .in_dest_x, .in_dest_z, .in_path_pos,
    .out_valid, .out_stall, .out_res(res)
  );

  assign out_status      = res.status;
  assign out_path_length = res.path_length;
  assign out_path_x      = res.path_x;
  assign out_path_z      = res.path_z;
  assign out_path_cost   = res.path_cost;

endmodule
`default_nettype wire
